// ----- rtl/core/gtpu_decap_header_parser_macros.svh -----
// Assertion helpers for the header parser
`ifndef GTPU_DECAP_HEADER_PARSER_MACROS_SVH
`define GTPU_DECAP_HEADER_PARSER_MACROS_SVH
// implication checked every edge outside reset
`define GTPD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gtpd check failed");
// next-cycle implication
`define GTPD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gtpd check failed");
`endif

// ----- rtl/core/gtpd_pkg.sv -----
package gtpd_pkg;
	localparam int OffsetWidth = 16;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_SHORT    = 3'd1,
		ST_UDP_LEN  = 3'd2,
		ST_TYPE     = 3'd3,
		ST_GTP_LEN  = 3'd4,
		ST_OPTIONS  = 3'd5,
		ST_EXT      = 3'd6
	} status_t;

	localparam logic [7:0] MsgGpdu      = 8'd255;
	localparam logic [7:0] MsgEndMarker = 8'd254;
	localparam logic [7:0] ExtRan       = 8'h84;
	localparam logic [7:0] ExtSession   = 8'h85;
	localparam logic [7:0] FlagsV1Pt    = 8'h30;
	localparam logic [7:0] FlagsVerMask = 8'hf8;

	// descriptor: fields from highest bit down (status sits in the lowest bits)
	typedef struct packed {
		logic        pdcp_sn_valid;
		logic [23:0] pdcp_sn;
		logic [7:0]  session_qos;
		logic [15:0] payload_bytes;
		logic [15:0] payload_start;
		logic [7:0]  message_kind;
		logic [15:0] source_port;
		logic [31:0] src_ip;
		logic [15:0] dest_port;
		logic [31:0] dst_ip;
		logic [31:0] tunnel_id;
		logic [2:0]  status;
	} desc_t;
endpackage

// ----- rtl/core/gtpu_decap_header_parser.sv -----
// GTP-U decapsulation header parser.
// s_axis: one packet byte per beat, tdata[7:0] = pkt_byte, tlast = last_byte.
// The packet starts at the first byte of the IPv4 header.
// m_axis: one descriptor beat per packet, issued for the tlast input beat.
// Latency: the descriptor is presented the cycle after the tlast beat is
// accepted. Throughput: one input beat per cycle unless stalled; each byte
// updates the header state registers through one level of compare/shift logic.
// s_axis_tready stays high while the output register is empty or being
// drained in the same cycle; it drops only if a descriptor is held by a
// stalled receiver and another tlast beat would need that slot, so
// non-last bytes keep flowing even under back pressure.
// Reset (arst_n low) clears all parsing state and empties the output
// register; a reset in mid-packet drops that packet.
// After every descriptor the parsing state is cleared for the next packet.
// Bytes at offset 65535 and beyond are counted no further and not parsed.
// Status codes: 0 ok, 1 short, 2 UDP length, 3 message type, 4 GTP length,
// 5 options missing, 6 bad extension chain.
module gtpu_decap_header_parser (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // [7:0] pkt_byte
	input  logic         s_axis_tlast,   // last_byte
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [207:0] m_axis_tdata    // status, tunnel_id, dst_ip, dest_port, src_ip,
	                                     // source_port, message_kind, payload_start,
	                                     // payload_bytes, session_qos, pdcp_sn,
	                                     // pdcp_sn_valid, zero pad
);
	import gtpd_pkg::*;
	`include "gtpu_decap_header_parser_macros.svh"

	logic [15:0] byte_index_q, ip_hlen_q, udp_length_q, gtp_length_q, rem_len_q;
	logic [7:0]  gtp_flags_q, msg_type_q, next_ext_q;
	logic [31:0] teid_q, src_ip_q, dst_ip_q, ext_meta_q;
	logic [15:0] source_port_q, dest_port_q;
	logic [9:0]  ext_pos_q, ext_size_q;
	logic [2:0]  err_q;
	logic [7:0]  qos_q;
	logic [23:0] sn_q;
	logic        sn_valid_q;
	logic        out_valid_q;
	desc_t       out_desc_q;

	logic        beat;
	assign s_axis_tready = !out_valid_q || m_axis_tready || !s_axis_tlast;
	assign beat = s_axis_tvalid && s_axis_tready;

	// next-state values of the parse registers
	logic [15:0] n_ip_hlen, n_udp_length, n_gtp_length, n_rem_len;
	logic [7:0]  n_gtp_flags, n_msg_type, n_next_ext, n_qos;
	logic [31:0] n_teid, n_src_ip, n_dst_ip, n_ext_meta;
	logic [15:0] n_source_port, n_dest_port;
	logic [9:0]  n_ext_pos, n_ext_size;
	logic [2:0]  n_err;
	logic [23:0] n_sn;
	logic        n_sn_valid;
	logic [15:0] n_index;

	logic [7:0]  b;
	logic [15:0] idx, u, gi, gbase;
	logic [9:0]  csize;
	logic [7:0]  meta_hi;
	logic        ran_ok, opts;

	always_comb begin
		b     = s_axis_tdata;
		idx   = byte_index_q;
		n_ip_hlen = ip_hlen_q; n_udp_length = udp_length_q;
		n_gtp_length = gtp_length_q; n_rem_len = rem_len_q;
		n_gtp_flags = gtp_flags_q; n_msg_type = msg_type_q; n_next_ext = next_ext_q;
		n_teid = teid_q; n_src_ip = src_ip_q; n_dst_ip = dst_ip_q;
		n_ext_meta = ext_meta_q; n_source_port = source_port_q; n_dest_port = dest_port_q;
		n_ext_pos = ext_pos_q; n_ext_size = ext_size_q; n_err = err_q;
		n_qos = qos_q; n_sn = sn_q; n_sn_valid = sn_valid_q;
		n_index = byte_index_q;
		// IHL from the first byte is already in force for that same byte
		if (idx == 16'd0)
			n_ip_hlen = {10'd0, b[3:0], 2'b00};
		gbase = n_ip_hlen + 16'd8;
		u = idx - n_ip_hlen;
		gi = idx - gbase;
		csize = {b, 2'b00};
		meta_hi = 8'd0;
		ran_ok = 1'b0;
		opts = (gtp_flags_q[2:0] != 3'd0);
		if (byte_index_q != 16'hffff) begin
			n_index = byte_index_q + 16'd1;
			if (idx >= 16'd12 && idx <= 16'd15)
				n_src_ip = {src_ip_q[23:0], b};
			if (idx >= 16'd16 && idx <= 16'd19)
				n_dst_ip = {dst_ip_q[23:0], b};
			// UDP header relative to IHL
			if (idx >= n_ip_hlen) begin
				if (u <= 16'd1)
					n_source_port = {source_port_q[7:0], b};
				else if (u <= 16'd3)
					n_dest_port = {dest_port_q[7:0], b};
				else if (u <= 16'd5)
					n_udp_length = {udp_length_q[7:0], b};
			end
			// GTP-U header and extensions
			if (idx >= gbase) begin
				if (gi == 16'd0)
					n_gtp_flags = b;
				else if (gi == 16'd1)
					n_msg_type = b;
				else if (gi <= 16'd3) begin
					n_gtp_length = {gtp_length_q[7:0], b};
					n_rem_len = {gtp_length_q[7:0], b};
				end else if (gi <= 16'd7) begin
					n_teid = {teid_q[23:0], b};
					if (gi == 16'd7) begin
						if (udp_length_q < 16'd16)
							n_err = ST_UDP_LEN;
						else if ((gtp_flags_q & FlagsVerMask) != FlagsV1Pt ||
							(msg_type_q != MsgGpdu && msg_type_q != MsgEndMarker))
							n_err = ST_TYPE;
						else if (gtp_length_q > udp_length_q - 16'd16)
							n_err = ST_GTP_LEN;
						else if (opts && rem_len_q < 16'd4)
							n_err = ST_OPTIONS;
						else if (opts)
							n_rem_len = rem_len_q - 16'd4;
					end
				end else if (gi == 16'd11)
					n_next_ext = b;
				else if (gi >= 16'd12 && err_q == ST_OK && gtp_flags_q[2] &&
					next_ext_q != 8'd0) begin
					// extension chain byte
					if (ext_pos_q == 10'd0 &&
						(csize == 10'd0 || {6'd0, csize} > rem_len_q)) begin
						n_err = ST_EXT;
					end else begin
						if (ext_pos_q == 10'd0) begin
							n_ext_size = csize;
							n_ext_meta = 32'd0;
						end
						if (ext_pos_q == 10'd1)
							n_ext_meta = {b, n_ext_meta[23:0]};
						else if (ext_pos_q == 10'd2) begin
							ran_ok = (ext_meta_q[31:28] == 4'd0) && b[3];
							n_ext_meta = {ran_ok, b[6:0], ext_meta_q[23:0]};
						end else if (ext_pos_q >= 10'd6 && ext_pos_q <= 10'd8)
							n_ext_meta = {ext_meta_q[31:24], ext_meta_q[15:0], b};
						meta_hi = n_ext_meta[31:24];
						if (ext_pos_q + 10'd1 == n_ext_size) begin
							if (next_ext_q == ExtSession)
								n_qos = {1'b1, meta_hi[6:0]};
							else if (next_ext_q == ExtRan && n_ext_size >= 10'd12 &&
								meta_hi[7]) begin
								n_sn = n_ext_meta[23:0];
								n_sn_valid = 1'b1;
							end
							n_rem_len = rem_len_q - {6'd0, n_ext_size};
							n_next_ext = b;
							n_ext_pos = 10'd0;
						end else
							n_ext_pos = ext_pos_q + 10'd1;
					end
				end
			end
		end
	end

	// descriptor built from the updated state on the last beat
	desc_t       d;
	logic [2:0]  st;
	logic [15:0] ng;
	always_comb begin
		ng = n_ip_hlen + 16'd8;
		if (n_index < 16'd36 || n_index < n_ip_hlen + 16'd16)
			st = ST_SHORT;
		else if (n_err != ST_OK)
			st = n_err;
		else if (n_gtp_flags[2] && (n_index < ng + 16'd12 || n_next_ext != 8'd0))
			st = ST_EXT;
		else
			st = ST_OK;
		d = '0;
		d.status       = st;
		d.tunnel_id    = n_teid;
		d.dst_ip       = n_dst_ip;
		d.dest_port    = n_dest_port;
		d.src_ip       = n_src_ip;
		d.source_port  = n_source_port;
		d.message_kind = n_msg_type;
		if (st == ST_OK) begin
			d.payload_start = ng + 16'd8 + (n_gtp_length - n_rem_len);
			d.payload_bytes = n_rem_len;
			d.session_qos   = n_qos;
			d.pdcp_sn       = n_sn;
			d.pdcp_sn_valid = n_sn_valid;
		end
	end

	// parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q <= '0; ip_hlen_q <= '0; udp_length_q <= '0;
			gtp_length_q <= '0; rem_len_q <= '0; gtp_flags_q <= '0;
			msg_type_q <= '0; next_ext_q <= '0; teid_q <= '0; src_ip_q <= '0;
			dst_ip_q <= '0; ext_meta_q <= '0; source_port_q <= '0; dest_port_q <= '0;
			ext_pos_q <= '0; ext_size_q <= '0; err_q <= '0; qos_q <= '0;
			sn_q <= '0; sn_valid_q <= 1'b0;
		end else if (beat) begin
			if (s_axis_tlast) begin
				byte_index_q <= '0; ip_hlen_q <= '0; udp_length_q <= '0;
				gtp_length_q <= '0; rem_len_q <= '0; gtp_flags_q <= '0;
				msg_type_q <= '0; next_ext_q <= '0; teid_q <= '0; src_ip_q <= '0;
				dst_ip_q <= '0; ext_meta_q <= '0; source_port_q <= '0; dest_port_q <= '0;
				ext_pos_q <= '0; ext_size_q <= '0; err_q <= '0; qos_q <= '0;
				sn_q <= '0; sn_valid_q <= 1'b0;
			end else begin
				byte_index_q <= n_index; ip_hlen_q <= n_ip_hlen;
				udp_length_q <= n_udp_length; gtp_length_q <= n_gtp_length;
				rem_len_q <= n_rem_len; gtp_flags_q <= n_gtp_flags;
				msg_type_q <= n_msg_type; next_ext_q <= n_next_ext; teid_q <= n_teid;
				src_ip_q <= n_src_ip; dst_ip_q <= n_dst_ip; ext_meta_q <= n_ext_meta;
				source_port_q <= n_source_port; dest_port_q <= n_dest_port;
				ext_pos_q <= n_ext_pos; ext_size_q <= n_ext_size; err_q <= n_err;
				qos_q <= n_qos; sn_q <= n_sn; sn_valid_q <= n_sn_valid;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (beat && s_axis_tlast) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (beat && s_axis_tlast)
			out_desc_q <= d;
	end

	// struct layout already has status in the lowest bits
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, out_desc_q};

	`GTPD_ASSERT_NXT(a_last_gives_valid, clk, arst_n, beat && s_axis_tlast, m_axis_tvalid)
	`GTPD_ASSERT_NXT(a_last_clears_index, clk, arst_n, beat && s_axis_tlast,
		byte_index_q == 16'd0)
	`GTPD_ASSERT_IMP(a_ok_has_no_err, clk, arst_n, beat && s_axis_tlast && d.status == ST_OK,
		n_err == ST_OK)
	`GTPD_ASSERT_IMP(a_no_overwrite, clk, arst_n, out_valid_q && !m_axis_tready && s_axis_tlast,
		!s_axis_tready)
endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;
	import gtpd_pkg::*;

	// GTP-U header bits used by the packet builder and the parse model
	localparam logic [7:0] FlagExt  = 8'h04;
	localparam logic [7:0] FlagOpts = 8'h07;
	localparam int         WdLimit  = 1000;
	localparam int         HoldLen  = 300;

	typedef enum int {
		K_SESS,
		K_RAN,
		K_GEN,
		K_ZERO,
		K_BIG
	} ext_kind_t;

	// one packet recipe; total < 0 means natural length, want < 0 means no typed status
	typedef struct {
		int ihl;
		int flags;
		int msg;
		int n_ext;
		int e0;
		int e1;
		int e2;
		int pay;
		int udp_delta;
		int gtp_delta;
		int total;
		int want;
	} pkt_spec_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata = 8'h00;   // [7:0] pkt_byte
	logic         s_axis_tlast = 1'b0;    // last_byte
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [207:0] m_axis_tdata;           // desc_t in [203:0], status lowest

	gtpu_decap_header_parser u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #6 clk = ~clk;

	// parser model state
	logic [31:0] pm_idx, pm_ihl, pm_udp, pm_flags, pm_msg, pm_glen, pm_teid;
	logic [31:0] pm_rem, pm_next, pm_epos, pm_esize, pm_meta, pm_err;
	logic [31:0] pm_src, pm_dst, pm_sport, pm_dport, pm_qos, pm_sn, pm_snv;

	desc_t desc_q[$];
	byte   pkt[$];
	int    errors = 0;
	int    bytes_sent = 0;
	int    idle_cycles = 0;
	bit    quiet = 1'b0;
	bit    hold_req = 1'b0;
	int    hold_cnt = 0;

	task automatic clear_parse();
		pm_idx = 0; pm_ihl = 0; pm_udp = 0; pm_flags = 0; pm_msg = 0; pm_glen = 0;
		pm_teid = 0; pm_rem = 0; pm_next = 0; pm_epos = 0; pm_esize = 0; pm_meta = 0;
		pm_err = 0; pm_src = 0; pm_dst = 0; pm_sport = 0; pm_dport = 0;
		pm_qos = 0; pm_sn = 0; pm_snv = 0;
	endtask

	// one byte of the extension-header chain
	task automatic ext_chain_byte(input logic [31:0] b);
		logic [31:0] sz;
		logic [31:0] ran_ok;
		if (pm_epos == 0) begin
			sz = b * 4;
			if (sz == 0 || sz > pm_rem) begin
				pm_err = 32'(ST_EXT);
				return;
			end
			pm_esize = sz;
			pm_meta = 0;
		end
		if (pm_epos == 1) begin
			pm_meta = (pm_meta & 32'h00ffffff) | (b << 24);
		end else if (pm_epos == 2) begin
			ran_ok = (((pm_meta >> 28) & 4'hf) == 0 && b[3]) ? 32'h80 : 32'h0;
			pm_meta = (pm_meta & 32'h00ffffff) | ((ran_ok | (b & 32'h7f)) << 24);
		end else if (pm_epos >= 6 && pm_epos <= 8) begin
			pm_meta = (pm_meta & 32'hff000000) | (((pm_meta & 32'hffff) << 8) | b);
		end
		if (pm_epos + 1 == pm_esize) begin
			if (pm_next == 32'(ExtSession)) begin
				pm_qos = 32'h80 | ((pm_meta >> 24) & 32'h7f);
			end else if (pm_next == 32'(ExtRan) && pm_esize >= 12 && pm_meta[31]) begin
				pm_sn = pm_meta & 32'hffffff;
				pm_snv = 1;
			end
			pm_rem = (pm_rem - pm_esize) & 32'hffff;
			pm_next = b;
			pm_epos = 0;
		end else begin
			pm_epos = (pm_epos + 1) & 32'h3ff;
		end
	endtask

	// header field capture for one byte at offset idx
	task automatic header_byte(input logic [31:0] idx, input logic [31:0] b);
		logic [31:0] u;
		logic [31:0] g;
		logic [31:0] k;
		logic        opts;
		if (idx == 0) pm_ihl = (b & 32'hf) << 2;
		if (idx >= 12 && idx <= 15) pm_src = (pm_src << 8) | b;
		if (idx >= 16 && idx <= 19) pm_dst = (pm_dst << 8) | b;
		if (idx >= pm_ihl) begin
			u = idx - pm_ihl;
			if (u <= 1) pm_sport = ((pm_sport << 8) | b) & 32'hffff;
			else if (u <= 3) pm_dport = ((pm_dport << 8) | b) & 32'hffff;
			else if (u <= 5) pm_udp = ((pm_udp << 8) | b) & 32'hffff;
		end
		g = pm_ihl + 8;
		if (idx < g) return;
		k = idx - g;
		if (k == 0) begin
			pm_flags = b;
		end else if (k == 1) begin
			pm_msg = b;
		end else if (k <= 3) begin
			pm_glen = ((pm_glen << 8) | b) & 32'hffff;
			pm_rem = pm_glen;
		end else if (k <= 7) begin
			pm_teid = (pm_teid << 8) | b;
			if (k == 7) begin
				opts = (pm_flags & 32'(FlagOpts)) != 0;
				if (pm_udp < 16)
					pm_err = 32'(ST_UDP_LEN);
				else if ((pm_flags & 32'(FlagsVerMask)) != 32'(FlagsV1Pt) ||
				         (pm_msg != 32'(MsgGpdu) && pm_msg != 32'(MsgEndMarker)))
					pm_err = 32'(ST_TYPE);
				else if (pm_glen > pm_udp - 16)
					pm_err = 32'(ST_GTP_LEN);
				else if (opts && pm_rem < 4)
					pm_err = 32'(ST_OPTIONS);
				else if (opts)
					pm_rem = pm_rem - 4;
			end
		end else if (k == 11) begin
			pm_next = b;
		end else if (k >= 12) begin
			if (pm_err == 0 && (pm_flags & 32'(FlagExt)) != 0 && pm_next != 0)
				ext_chain_byte(b);
		end
	endtask

	// advance the model by one accepted byte; gives a descriptor on the last one
	task automatic desc_predict(input logic [7:0] b, input logic last,
	                            output bit has, output desc_t d);
		logic [31:0] g;
		logic [31:0] st;
		has = 1'b0;
		d = '0;
		if (pm_idx < 32'hffff) begin
			header_byte(pm_idx, 32'(b));
			pm_idx++;
		end
		if (!last) return;
		g = pm_ihl + 8;
		if (pm_idx < 36 || pm_idx < pm_ihl + 16) st = 32'(ST_SHORT);
		else if (pm_err != 0) st = pm_err;
		else if ((pm_flags & 32'(FlagExt)) != 0 && (pm_idx < g + 12 || pm_next != 0))
			st = 32'(ST_EXT);
		else st = 32'(ST_OK);
		has = 1'b1;
		d.status = st[2:0];
		d.tunnel_id = pm_teid;
		d.dst_ip = pm_dst;
		d.dest_port = pm_dport[15:0];
		d.src_ip = pm_src;
		d.source_port = pm_sport[15:0];
		d.message_kind = pm_msg[7:0];
		if (st == 32'(ST_OK)) begin
			d.payload_start = 16'(g + 8 + (pm_glen - pm_rem));
			d.payload_bytes = pm_rem[15:0];
			d.session_qos = pm_qos[7:0];
			d.pdcp_sn = pm_sn[23:0];
			d.pdcp_sn_valid = pm_snv[0];
		end
		clear_parse();
	endtask

	function automatic logic [7:0] ext_code(input int kind);
		logic [7:0] c;
		if (kind == K_SESS) return ExtSession;
		if (kind == K_RAN) return ExtRan;
		c = 8'($urandom_range(1, 255));
		return c;
	endfunction

	// lay out one IPv4/UDP/GTP-U packet into pkt
	task automatic build_pkt(input pkt_spec_t s);
		byte eq[$];
		int  kinds[3];
		logic [7:0] codes[3];
		int  g, opt, glen, udp, total, n, L, i, k;
		byte arr[];
		kinds[0] = s.e0; kinds[1] = s.e1; kinds[2] = s.e2;
		for (k = 0; k < 3; k++) codes[k] = ext_code(kinds[k]);
		g = s.ihl * 4 + 8;
		opt = (s.flags & 7) ? 4 : 0;
		for (k = 0; k < s.n_ext; k++) begin
			if (kinds[k] == K_ZERO) begin
				eq.push_back(8'h00);
				break;
			end
			if (kinds[k] == K_BIG) begin
				eq.push_back(8'd63);
				break;
			end
			L = (kinds[k] == K_SESS) ? 1 : (kinds[k] == K_RAN) ? 3 : $urandom_range(1, 3);
			eq.push_back(byte'(L));
			for (i = 0; i < 4 * L - 2; i++) eq.push_back(byte'($urandom));
			if (kinds[k] == K_RAN) begin
				n = eq.size() - (4 * L - 2);
				if ($urandom_range(0, 3) != 0) eq[n] = eq[n] & 8'h0f;
				if ($urandom_range(0, 3) != 0) eq[n + 1] = eq[n + 1] | 8'h08;
			end
			eq.push_back((k == s.n_ext - 1) ? 8'h00 : codes[k + 1]);
		end
		glen = opt + eq.size() + s.pay + s.gtp_delta;
		udp = glen + 16 + s.udp_delta;
		total = (s.total >= 0) ? s.total : g + 8 + opt + eq.size() + s.pay;
		n = (total > g + 12 + eq.size()) ? total : g + 12 + eq.size();
		arr = new[n];
		foreach (arr[i]) arr[i] = byte'($urandom);
		arr[0] = (arr[0] & 8'hf0) | byte'(s.ihl);
		arr[s.ihl * 4 + 4] = byte'(udp >> 8);
		arr[s.ihl * 4 + 5] = byte'(udp);
		arr[g] = byte'(s.flags);
		arr[g + 1] = byte'(s.msg);
		arr[g + 2] = byte'(glen >> 8);
		arr[g + 3] = byte'(glen);
		if (s.n_ext > 0 && (s.flags & FlagExt)) arr[g + 11] = codes[0];
		foreach (eq[i]) arr[g + 12 + i] = eq[i];
		pkt.delete();
		for (i = 0; i < total; i++) pkt.push_back(arr[i]);
	endtask

	// offer one byte until accepted; once offered it is held; the model steps on acceptance
	task automatic send_byte(input logic [7:0] b, input logic last, input int want);
		bit    has;
		desc_t d;
		bit    offered;
		offered = 1'b0;
		forever begin
			@(negedge clk);
			if (!offered && !quiet && $urandom_range(0, 99) < 36) begin
				s_axis_tvalid <= 1'b0;
			end else begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= b;
				s_axis_tlast <= last;
				offered = 1'b1;
			end
			@(posedge clk);
			if (s_axis_tvalid && s_axis_tready) break;
		end
		bytes_sent++;
		desc_predict(b, last, has, d);
		if (has) begin
			if (want >= 0) d.status = 3'(want);
			desc_q.push_back(d);
		end
	endtask

	task automatic send_pkt(input pkt_spec_t s);
		int i;
		build_pkt(s);
		for (i = 0; i < pkt.size(); i++)
			send_byte(pkt[i], i == pkt.size() - 1, s.want);
	endtask

	task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
		errors++;
		if (errors <= 50) $display("mismatch %s: got %h want %h", field, got, want);
	endtask

	// receiver ready, with one long hold-off on request
	always @(negedge clk) begin
		if (hold_req && hold_cnt == 0) begin
			hold_cnt = HoldLen;
			hold_req = 1'b0;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= quiet || ($urandom_range(0, 99) >= 36);
		end
	end

	// descriptor check and watchdog
	always @(posedge clk) begin
		desc_t got;
		desc_t want;
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WdLimit) begin
				$display("== FAIL ==");
				$finish;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = desc_t'(m_axis_tdata[203:0]);
				if (desc_q.size() == 0) begin
					report("unexpected beat", 32'(got.status), 0);
				end else begin
					want = desc_q.pop_front();
					if (got.status != want.status) report("status", 32'(got.status), 32'(want.status));
					if (got.tunnel_id != want.tunnel_id) report("tunnel_id", got.tunnel_id, want.tunnel_id);
					if (got.dst_ip != want.dst_ip) report("dst_ip", got.dst_ip, want.dst_ip);
					if (got.dest_port != want.dest_port)
						report("dest_port", 32'(got.dest_port), 32'(want.dest_port));
					if (got.src_ip != want.src_ip) report("src_ip", got.src_ip, want.src_ip);
					if (got.source_port != want.source_port)
						report("source_port", 32'(got.source_port), 32'(want.source_port));
					if (got.message_kind != want.message_kind)
						report("message_kind", 32'(got.message_kind), 32'(want.message_kind));
					if (got.payload_start != want.payload_start)
						report("payload_start", 32'(got.payload_start), 32'(want.payload_start));
					if (got.payload_bytes != want.payload_bytes)
						report("payload_bytes", 32'(got.payload_bytes), 32'(want.payload_bytes));
					if (got.session_qos != want.session_qos)
						report("session_qos", 32'(got.session_qos), 32'(want.session_qos));
					if (got.pdcp_sn != want.pdcp_sn) report("pdcp_sn", 32'(got.pdcp_sn), 32'(want.pdcp_sn));
					if (got.pdcp_sn_valid != want.pdcp_sn_valid)
						report("pdcp_sn_valid", 32'(got.pdcp_sn_valid), 32'(want.pdcp_sn_valid));
				end
			end
		end
	end

	// directed packets: ihl, flags, msg, n_ext, e0, e1, e2, pay, udp_d, gtp_d, total, status
	pkt_spec_t dir_tab[] = '{
		'{5, 'h30, 255, 0, K_SESS, K_SESS, K_SESS, 0, 0, 0, -1, ST_OK},
		'{5, 'h30, 255, 0, K_SESS, K_SESS, K_SESS, 4, 0, 0, 10, ST_SHORT},
		'{5, 'h30, 255, 0, K_SESS, K_SESS, K_SESS, 4, -10, 0, -1, ST_UDP_LEN},
		'{5, 'h20, 255, 0, K_SESS, K_SESS, K_SESS, 4, 0, 0, -1, ST_TYPE},
		'{5, 'h30, 1, 0, K_SESS, K_SESS, K_SESS, 4, 0, 0, -1, ST_TYPE},
		'{5, 'h30, 255, 0, K_SESS, K_SESS, K_SESS, 4, -5, 5, -1, ST_GTP_LEN},
		'{5, 'h32, 255, 0, K_SESS, K_SESS, K_SESS, 0, 0, -2, -1, ST_OPTIONS},
		'{5, 'h34, 255, 1, K_ZERO, K_SESS, K_SESS, 4, 0, 0, -1, ST_EXT},
		'{5, 'h34, 255, 1, K_BIG, K_SESS, K_SESS, 4, 0, 0, -1, ST_EXT},
		'{5, 'h34, 255, 2, K_SESS, K_SESS, K_SESS, 4, 0, 0, 42, ST_EXT},
		'{5, 'h31, 255, 0, K_SESS, K_SESS, K_SESS, 6, 0, 0, -1, -1},
		'{2, 'h30, 255, 0, K_SESS, K_SESS, K_SESS, 8, 0, 0, -1, -1},
		'{0, 'h30, 255, 0, K_SESS, K_SESS, K_SESS, 8, 0, 0, -1, -1},
		'{15, 'h30, 255, 0, K_SESS, K_SESS, K_SESS, 3, 0, 0, -1, -1},
		'{5, 'h34, 255, 1, K_SESS, K_SESS, K_SESS, 6, 0, 0, -1, -1},
		'{5, 'h34, 255, 1, K_RAN, K_SESS, K_SESS, 5, 0, 0, -1, -1},
		'{5, 'h37, 255, 3, K_RAN, K_SESS, K_GEN, 7, 0, 0, -1, -1},
		'{5, 'h30, 254, 0, K_SESS, K_SESS, K_SESS, 2, 0, 0, -1, ST_OK}
	};

	initial begin
		pkt_spec_t s;
		int        n_rand;
		clear_parse();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_tab[i]) send_pkt(dir_tab[i]);

		n_rand = 0;
		while (bytes_sent < 1550 || n_rand < 16) begin
			quiet = (n_rand >= 10 && n_rand < 15);
			if (n_rand == 5) hold_req = 1'b1;
			s.ihl = ($urandom_range(0, 9) < 8) ? 5 : $urandom_range(0, 15);
			if ($urandom_range(0, 9) < 8) begin
				s.flags = 'h30 | $urandom_range(0, 7);
				s.msg = $urandom_range(0, 1) ? 255 : 254;
			end else begin
				s.flags = $urandom_range(0, 255);
				s.msg = $urandom_range(0, 255);
			end
			s.n_ext = (s.flags & FlagExt) ? $urandom_range(0, 3) : 0;
			s.e0 = ($urandom_range(0, 9) == 0) ? $urandom_range(K_ZERO, K_BIG) : $urandom_range(K_SESS, K_GEN);
			s.e1 = $urandom_range(K_SESS, K_GEN);
			s.e2 = $urandom_range(K_SESS, K_GEN);
			s.pay = $urandom_range(0, 24);
			s.udp_delta = ($urandom_range(0, 99) < 15) ? $urandom_range(0, 16) - 8 : 0;
			s.gtp_delta = ($urandom_range(0, 99) < 15) ? $urandom_range(0, 16) - 8 : 0;
			s.total = ($urandom_range(0, 99) < 15) ? $urandom_range(0, 80) : -1;
			s.want = -1;
			send_pkt(s);
			n_rand++;
		end
		quiet = 1'b0;
		@(negedge clk);
		s_axis_tvalid <= 1'b0;

		while (desc_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

// ----- gtpu_decap_header_parser.f -----
+incdir+rtl/core
rtl/core/gtpd_pkg.sv
rtl/core/gtpu_decap_header_parser.sv
tb/sv/tb_top.sv
